>>> design/cdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Countdown timer package
// Shared types and constants for the MM:SS countdown timer.
// ---------------------------------------------------------------------------
package cdt_pkg;

  // Input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DIGIT = 1'b1;

  // Entry geometry
  localparam int unsigned NUM_DIGITS  = 4;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIGIT_IDX_W = 2;
  localparam int unsigned POS_W       = 3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // Count and prescaler
  localparam int unsigned SECS_W = 13;
  localparam int unsigned TPS_W  = 8;
  localparam logic [TPS_W-1:0] TPS_RESET = 8'd14;

  typedef enum logic [1:0] {
    STATUS_IDLE     = 2'd0,
    STATUS_RUNNING  = 2'd1,
    STATUS_PAUSED   = 2'd2,
    STATUS_FINISHED = 2'd3
  } status_e;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic               show_countdown;
    status_e            status;
    logic [SECS_W-1:0]  seconds_left;
    digit_t             minute_tens;
    digit_t             minute_units;
    digit_t             second_tens;
    digit_t             second_units;
  } result_t;

endpackage
`default_nettype wire

>>> design/countdown_timer_with_pause.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Countdown timer with pause
// MM:SS entry and per-second countdown driven by tick and digit transfers.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | sink      | in_valid_i/in_stall_o | command, start/pause, digit
//  out     | source    | out_valid_o/out_stall_i | status, seconds, digits
//  cfg     | sink      | cfg_we_i              | ticks per second
//
//  One transfer in, one result out; a new transfer can be taken every cycle while in_stall_o is low.
//  State is updated at the accepting edge; the result is written at that same
//  edge into the output register, or into the skid if that register is held.
//  A one-entry skid register sits behind the output register, so in_stall_o
//  is a registered signal and rises only when both hold results.
//  rst_ni (async, active low) returns the timer to idle entry with
//  ticks per second at 14; result registers are not reset.
//
module countdown_timer_with_pause (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [cdt_pkg::TPS_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          command_i,
  input  wire logic                          start_press_i,
  input  wire logic                          pause_press_i,
  input  wire logic [cdt_pkg::DIGIT_W-1:0]   digit_value_i,
  // output channel
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          show_countdown_o,
  output      logic [1:0]                    status_o,
  output      logic [cdt_pkg::SECS_W-1:0]    seconds_left_o,
  output      logic [cdt_pkg::DIGIT_W-1:0]   minute_tens_o,
  output      logic [cdt_pkg::DIGIT_W-1:0]   minute_units_o,
  output      logic [cdt_pkg::DIGIT_W-1:0]   second_tens_o,
  output      logic [cdt_pkg::DIGIT_W-1:0]   second_units_o
);

  typedef enum logic [1:0] {
    RUN_IDLE     = 2'd0,
    RUN_RUNNING  = 2'd1,
    RUN_FINISHED = 2'd3
  } run_e;

  // -------------------------------------------------------------------------
  // Timer state
  // -------------------------------------------------------------------------
  logic [cdt_pkg::TPS_W-1:0]   tps_q;
  logic                        disp_q, disp_d;     // 1: countdown shown
  run_e                        run_q, run_d;
  logic                        paused_q, paused_d;
  cdt_pkg::digit_t             digits_q [cdt_pkg::NUM_DIGITS];
  cdt_pkg::digit_t             digits_d [cdt_pkg::NUM_DIGITS];
  logic [cdt_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [cdt_pkg::TPS_W-1:0]   tick_q, tick_d;
  logic [cdt_pkg::SECS_W-1:0]  rem_q, rem_d;
  logic                        remv_q, remv_d;     // count held

  // Output register and skid
  cdt_pkg::result_t            out_q, skid_q, res_d;
  logic                        out_valid_q, skid_valid_q;

  logic                        in_acc, out_take;
  logic                        skip_tick;
  logic [cdt_pkg::TPS_W-1:0]   tick_inc;
  cdt_pkg::digit_t             digit_clamped;
  logic [cdt_pkg::SECS_W-1:0]  load_secs;
  logic [cdt_pkg::SECS_W-1:0]  minutes;
  cdt_pkg::status_e            status_d;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // Digits above nine stored as nine
  assign digit_clamped = (digit_value_i > cdt_pkg::DIGIT_MAX) ? cdt_pkg::DIGIT_MAX
                                                             : digit_value_i;

  // Seconds from MM:SS; constant multiplies only (max 99*60+99 = 6039)
  assign minutes   = cdt_pkg::SECS_W'(digits_q[0]) * cdt_pkg::SECS_W'(10)
                   + cdt_pkg::SECS_W'(digits_q[1]);
  assign load_secs = minutes * cdt_pkg::SECS_W'(60)
                   + cdt_pkg::SECS_W'(digits_q[2]) * cdt_pkg::SECS_W'(10)
                   + cdt_pkg::SECS_W'(digits_q[3]);

  assign tick_inc = tick_q + cdt_pkg::TPS_W'(1);

  // -------------------------------------------------------------------------
  // Next state: a digit stores one entry digit; a tick does start, pause, then prescaler
  // -------------------------------------------------------------------------
  always_comb begin
    disp_d    = disp_q;
    run_d     = run_q;
    paused_d  = paused_q;
    digits_d  = digits_q;
    pos_d     = pos_q;
    tick_d    = tick_q;
    rem_d     = rem_q;
    remv_d    = remv_q;
    skip_tick = 1'b0;

    if (command_i == cdt_pkg::CMD_DIGIT) begin
      // Fifth and later digits dropped until the entry is cleared
      if (pos_q < cdt_pkg::POS_W'(cdt_pkg::NUM_DIGITS)) begin
        digits_d[pos_q[cdt_pkg::DIGIT_IDX_W-1:0]] = digit_clamped;
        pos_d = pos_q + cdt_pkg::POS_W'(1);
      end
    end else begin
      if (start_press_i) begin
        if (paused_q) begin
          // resume only; tick not counted
          paused_d  = 1'b0;
          skip_tick = 1'b1;
        end else if (run_q == RUN_FINISHED) begin
          // back to entry; tick not counted
          disp_d    = 1'b0;
          digits_d  = '{default: '0};
          pos_d     = '0;
          run_d     = RUN_IDLE;
          skip_tick = 1'b1;
        end else begin
          disp_d = 1'b1;
          run_d  = RUN_RUNNING;
          rem_d  = load_secs;
          remv_d = 1'b1;
        end
      end

      if (!skip_tick) begin
        if (pause_press_i) begin
          if (!disp_d) begin
            digits_d = '{default: '0};
            pos_d    = '0;
            run_d    = RUN_IDLE;
          end
          if (run_d == RUN_RUNNING) begin
            paused_d = 1'b1;
          end
        end

        tick_d = tick_inc;
        if (tick_inc == tps_q) begin
          if (run_d == RUN_RUNNING && remv_d && rem_d != '0 && !paused_d) begin
            rem_d = rem_d - cdt_pkg::SECS_W'(1);
          end
          // zero count finishes even when paused
          if (remv_d && rem_d == '0) begin
            run_d  = RUN_FINISHED;
            remv_d = 1'b0;
            rem_d  = '0;
          end
          tick_d = '0;
        end
      end
    end
  end

  // Status from the post-step state
  always_comb begin
    unique case (run_d)
      RUN_FINISHED: status_d = cdt_pkg::STATUS_FINISHED;
      RUN_RUNNING:  status_d = paused_d ? cdt_pkg::STATUS_PAUSED
                                        : cdt_pkg::STATUS_RUNNING;
      default:      status_d = cdt_pkg::STATUS_IDLE;
    endcase
  end

  always_comb begin
    res_d.show_countdown = disp_d;
    res_d.status         = status_d;
    res_d.seconds_left   = remv_d ? rem_d : '0;
    res_d.minute_tens    = digits_d[0];
    res_d.minute_units   = digits_d[1];
    res_d.second_tens    = digits_d[2];
    res_d.second_units   = digits_d[3];
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= cdt_pkg::TPS_RESET;
      disp_q   <= 1'b0;
      run_q    <= RUN_IDLE;
      paused_q <= 1'b0;
      digits_q <= '{default: '0};
      pos_q    <= '0;
      tick_q   <= '0;
      rem_q    <= '0;
      remv_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_data_i;
      end
      if (in_acc) begin
        disp_q   <= disp_d;
        run_q    <= run_d;
        paused_q <= paused_d;
        digits_q <= digits_d;
        pos_q    <= pos_d;
        tick_q   <= tick_d;
        rem_q    <= rem_d;
        remv_q   <= remv_d;
      end
    end
  end

  // Result handshake: output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign show_countdown_o = out_q.show_countdown;
  assign status_o         = out_q.status;
  assign seconds_left_o   = out_q.seconds_left;
  assign minute_tens_o    = out_q.minute_tens;
  assign minute_units_o   = out_q.minute_units;
  assign second_tens_o    = out_q.second_tens;
  assign second_units_o   = out_q.second_units;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cdt_pkg::POS_W'(cdt_pkg::NUM_DIGITS))
    else $error("entry position past last digit");

  a_count_iff_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remv_q == (run_q == RUN_RUNNING))
    else $error("count held out of step with run state");

  a_paused_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> (run_q != RUN_IDLE))
    else $error("paused while idle");

  a_stall_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("result dropped on stalled output");

endmodule
`default_nettype wire
